### rtl/core/sorted_priority_queue_unit_assert.svh
// Assertion macros for the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while the given condition holds.
`define SPQ_ASSERT_IMPLY(label, clk, off, ante, cons) \
  label: assert property (@(posedge clk) disable iff (off) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Next-cycle implication, disabled while the given condition holds.
`define SPQ_ASSERT_NEXT(label, clk, off, ante, cons) \
  label: assert property (@(posedge clk) disable iff (off) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

### rtl/core/spq_pkg.sv
// Types and constants shared by the sorted priority queue modules.
package spq_pkg;

  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned AGE_W    = 8;
  localparam int unsigned TAG_W    = 64;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Priority sits in the lowest bits, matching the stream packing.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [AGE_W-1:0]  age;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);
  localparam int unsigned OUT_USER_W = STATUS_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ENQ_PRIME,
    S_ENQ_WALK,
    S_ENQ_PLACE,
    S_HEAD_RD,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    prime;
    logic    shift;
    logic    place;
    logic    head_rd;
    logic    load;
    logic    with_head;
    logic    pop;
    status_t status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic greater;
    logic last;
    logic out_free;
  } stat_t;

endpackage

### rtl/core/spq_ctrl.sv
// Controller state machine for the sorted priority queue.
module spq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  spq_pkg::stat_t stat,
  output spq_pkg::cmd_t  cmd
);

  spq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = spq_pkg::S_DISPATCH;
        end
      end
      spq_pkg::S_DISPATCH: begin
        case (stat.op)
          spq_pkg::OP_ENQ: begin
            state_next = stat.full ? spq_pkg::S_RESULT : spq_pkg::S_ENQ_PRIME;
          end
          spq_pkg::OP_DEQ, spq_pkg::OP_PEEK: begin
            state_next = stat.empty ? spq_pkg::S_RESULT : spq_pkg::S_HEAD_RD;
          end
          default: begin
            state_next = spq_pkg::S_RESULT;
          end
        endcase
      end
      spq_pkg::S_ENQ_PRIME: begin
        state_next = stat.empty ? spq_pkg::S_ENQ_PLACE : spq_pkg::S_ENQ_WALK;
      end
      spq_pkg::S_ENQ_WALK: begin
        if (!stat.greater || stat.last) begin
          state_next = spq_pkg::S_ENQ_PLACE;
        end
      end
      spq_pkg::S_ENQ_PLACE: begin
        state_next = spq_pkg::S_RESULT;
      end
      spq_pkg::S_HEAD_RD: begin
        state_next = spq_pkg::S_RESULT;
      end
      spq_pkg::S_RESULT: begin
        if (stat.out_free) begin
          state_next = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    cmd.status = spq_pkg::ST_OK;
    case (state)
      spq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      spq_pkg::S_ENQ_PRIME: begin
        cmd.prime = 1'b1;
      end
      spq_pkg::S_ENQ_WALK: begin
        cmd.shift = stat.greater;
      end
      spq_pkg::S_ENQ_PLACE: begin
        cmd.place = 1'b1;
      end
      spq_pkg::S_HEAD_RD: begin
        cmd.head_rd = 1'b1;
      end
      spq_pkg::S_RESULT: begin
        cmd.load = stat.out_free;
        case (stat.op)
          spq_pkg::OP_ENQ: begin
            cmd.status = stat.full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
          end
          spq_pkg::OP_DEQ, spq_pkg::OP_PEEK: begin
            cmd.status = stat.empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
            cmd.with_head = !stat.empty;
            cmd.pop = (stat.op == spq_pkg::OP_DEQ) && !stat.empty;
          end
          default: begin
            cmd.status = spq_pkg::ST_OK;
          end
        endcase
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/spq_datapath.sv
// Datapath of the sorted priority queue: circular entry store, walk pointers and output register.
module spq_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [spq_pkg::ENTRY_W-1:0]       in_data,
  input  logic [spq_pkg::OP_W-1:0]          in_user,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [spq_pkg::ENTRY_W-1:0]       out_data,
  output logic [spq_pkg::OUT_USER_W-1:0]    out_user,
  input  spq_pkg::cmd_t                     cmd,
  output spq_pkg::stat_t                    stat
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;

  function automatic logic [AW-1:0] wrap_prev(input logic [AW-1:0] p);
    return (p == '0) ? AW'(CAPACITY - 1) : AW'(p - 1'b1);
  endfunction

  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
    return (p == AW'(CAPACITY - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  spq_pkg::entry_t mem [CAPACITY];

  logic [AW-1:0]       head;
  logic [CW-1:0]       count;
  logic [AW-1:0]       ins_ptr;
  logic [CW-1:0]       left;
  spq_pkg::op_t        op;
  logic                full;
  logic                empty;
  spq_pkg::entry_t     new_entry;
  spq_pkg::entry_t     rd_data;
  spq_pkg::entry_t     out_entry;
  spq_pkg::status_t    out_status;
  logic                out_head;

  logic [SW-1:0]       tail_sum;
  logic [AW-1:0]       tail;
  logic [AW-1:0]       prev_ins;
  logic [AW-1:0]       prev2_ins;
  logic [AW-1:0]       rd_addr;
  logic                rd_en;
  logic                wr_en;
  spq_pkg::entry_t     wr_data;

  // The tail slot is head plus occupancy, folded back into the ring.
  assign tail_sum = SW'(head) + SW'(count);
  assign tail = (tail_sum >= SW'(CAPACITY)) ? AW'(tail_sum - SW'(CAPACITY)) : AW'(tail_sum);

  assign prev_ins  = wrap_prev(ins_ptr);
  assign prev2_ins = wrap_prev(prev_ins);

  // While shifting, the entry below the one being compared is fetched ahead.
  assign rd_en   = cmd.prime | cmd.shift | cmd.head_rd;
  assign rd_addr = cmd.head_rd ? head : (cmd.shift ? prev2_ins : prev_ins);
  assign wr_en   = cmd.shift | cmd.place;
  assign wr_data = cmd.place ? new_entry : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ins_ptr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op        <= spq_pkg::op_t'(in_user);
      new_entry <= spq_pkg::entry_t'(in_data);
      full      <= (count == CW'(CAPACITY));
      empty     <= (count == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      ins_ptr <= '0;
      left    <= '0;
    end else begin
      if (cmd.accept) begin
        ins_ptr <= tail;
        left    <= count;
      end else if (cmd.shift) begin
        ins_ptr <= prev_ins;
        left    <= left - CW'(1);
      end
      if (cmd.place) begin
        count <= count + CW'(1);
      end else if (cmd.load && cmd.pop) begin
        head  <= wrap_next(head);
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status <= cmd.status;
      out_head   <= cmd.with_head;
      out_entry  <= cmd.with_head ? rd_data : '0;
    end
  end

  assign out_data = out_entry;
  assign out_user = {out_head, out_status};

  always_comb begin
    stat.op       = op;
    stat.full     = full;
    stat.empty    = empty;
    stat.greater  = (rd_data.prio > new_entry.prio);
    stat.last     = (left == CW'(1));
    stat.out_free = !out_valid || out_ready;
  end

endmodule

### rtl/core/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue.
//
//  channel | direction | tdata                          | tuser
//  s_axis  | in        | prio[15:0] age[23:16] tag[87:24] | op[1:0]
//  m_axis  | out       | prio[15:0] age[23:16] tag[87:24] | status[1:0] entry_valid[2]
//
// One transaction at a time. An enqueue walks down from the tail of the store,
// moving one entry per cycle (one read, one write port) until it finds its place.
// The next transaction can be accepted in the cycle after its result is loaded.
// Reset (rst, synchronous) empties the queue; the memory itself is not cleared.
// A result held by the sink stalls only the one after it, which waits in the controller.
module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [spq_pkg::ENTRY_W-1:0]         s_axis_tdata,  // prio, age, tag
  input  logic [spq_pkg::OP_W-1:0]            s_axis_tuser,  // op
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [spq_pkg::ENTRY_W-1:0]         m_axis_tdata,  // prio, age, tag
  output logic [spq_pkg::OUT_USER_W-1:0]      m_axis_tuser   // status, entry_valid
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

### rtl/core/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
`include "sorted_priority_queue_unit_assert.svh"

module spq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [spq_pkg::ENTRY_W-1:0]         m_axis_tdata,
  input logic [spq_pkg::OUT_USER_W-1:0]      m_axis_tuser
);

  // A result held back by the sink must not change.
  `SPQ_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Nothing is offered right after reset.
  `SPQ_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !m_axis_tvalid)

  // A returned head entry always comes with a good status.
  `SPQ_ASSERT_IMPLY(a_head_ok, clk, rst, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == 2'd0)

  // Without a head entry the entry fields read as zero.
  `SPQ_ASSERT_IMPLY(a_no_head_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[2], m_axis_tdata == '0)

  // An accepted transaction closes the input before the next one can be taken.
  `SPQ_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### tb/sorted_priority_queue_unit_test.sv
// Self-checking testbench for the sorted priority queue unit.
`timescale 1ns / 100ps

module sorted_priority_queue_unit_test;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum int unsigned {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  typedef struct packed {
    spq_pkg::status_t status;
    logic             valid;
    spq_pkg::entry_t  entry;
  } outcome_t;

  // Mirrors the sorted store and holds the outcomes still owed by the block.
  class queue_checker;
    spq_pkg::entry_t stored[$];
    outcome_t        awaited[$];
    int unsigned     faults;

    function void note_request(spq_pkg::op_t op, spq_pkg::entry_t item);
      outcome_t    res;
      int unsigned pos;
      res = '0;
      res.status = spq_pkg::ST_OK;
      case (op)
        spq_pkg::OP_ENQ: begin
          if (stored.size() >= CAPACITY) begin
            res.status = spq_pkg::ST_FULL;
          end else begin
            // Equal priorities stay behind earlier arrivals.
            pos = 0;
            while (pos < stored.size() && stored[pos].prio <= item.prio) pos++;
            stored.insert(pos, item);
          end
        end
        spq_pkg::OP_DEQ, spq_pkg::OP_PEEK: begin
          if (stored.size() == 0) begin
            res.status = spq_pkg::ST_EMPTY;
          end else begin
            res.valid = 1'b1;
            res.entry = stored[0];
            if (op == spq_pkg::OP_DEQ) void'(stored.pop_front());
          end
        end
        default: ;
      endcase
      awaited.push_back(res);
    endfunction

    function void check_response(logic [spq_pkg::ENTRY_W-1:0] data,
                                 logic [spq_pkg::OUT_USER_W-1:0] user);
      outcome_t        want;
      spq_pkg::entry_t got;
      got = data;
      if (awaited.size() == 0) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("%0t: result with nothing outstanding: user %h data %h", $time, user, data);
        return;
      end
      want = awaited.pop_front();
      if (user[spq_pkg::STATUS_W-1:0] !== want.status ||
          user[spq_pkg::STATUS_W] !== want.valid ||
          got.prio !== want.entry.prio || got.age !== want.entry.age ||
          got.tag !== want.entry.tag) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("%0t: mismatch: status %0d/%0d valid %0d/%0d prio %h/%h age %h/%h tag %h/%h",
                   $time, want.status, user[spq_pkg::STATUS_W-1:0], want.valid,
                   user[spq_pkg::STATUS_W],
                   want.entry.prio, got.prio, want.entry.age, got.age,
                   want.entry.tag, got.tag);
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [spq_pkg::ENTRY_W-1:0]    s_axis_tdata = '0;    // prio, age, tag
  logic [spq_pkg::OP_W-1:0]       s_axis_tuser = '0;    // op
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [spq_pkg::ENTRY_W-1:0]    m_axis_tdata;         // prio, age, tag
  logic [spq_pkg::OUT_USER_W-1:0] m_axis_tuser;         // status, entry_valid

  queue_checker board;
  bit           no_idle = 1'b0;
  int unsigned  cycles = 0;

  sorted_priority_queue_unit #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Presents one request and returns once the block has accepted it.
  task automatic offer(spq_pkg::op_t op, logic [spq_pkg::PRIO_W-1:0] prio,
                       logic [spq_pkg::AGE_W-1:0] age, logic [spq_pkg::TAG_W-1:0] tag);
    spq_pkg::entry_t item;
    int unsigned     gap;
    item.prio = prio;
    item.age  = age;
    item.tag  = tag;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(op, item);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Result side: random back-pressure before each result, none while no_idle is set.
  initial begin
    int unsigned stall;
    wait (!rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      board.check_response(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    int unsigned                k;
    int unsigned                roll;
    int unsigned                enq_share;
    mix_t                       mix;
    spq_pkg::op_t               op;
    logic [spq_pkg::PRIO_W-1:0] prio;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty queue, the unused code, then a fill with extreme values and ties.
    offer(spq_pkg::OP_DEQ, 16'h0000, 8'h00, '0);
    offer(spq_pkg::OP_PEEK, 16'hFFFF, 8'hFF, '1);
    offer(spq_pkg::OP_NONE, 16'h1234, 8'h56, {8{8'h5A}});
    offer(spq_pkg::OP_ENQ, 16'd100, 8'h00, '0);
    offer(spq_pkg::OP_ENQ, 16'hFFFF, 8'hFF, '1);
    offer(spq_pkg::OP_ENQ, 16'h0000, 8'h55, {8{8'hAA}});
    offer(spq_pkg::OP_ENQ, 16'd100, 8'h01, 64'd1);
    offer(spq_pkg::OP_ENQ, 16'd100, 8'h02, 64'd2);
    offer(spq_pkg::OP_ENQ, 16'h0000, 8'hAA, {8{8'h55}});
    for (k = 0; k < CAPACITY - 6; k++)
      offer(spq_pkg::OP_ENQ, 16'(k * 6007), 8'(k), {32'(k), ~32'(k)});
    // The queue is full now, so this one must be refused.
    offer(spq_pkg::OP_ENQ, 16'h0000, 8'h77, {8{8'h77}});
    offer(spq_pkg::OP_PEEK, '0, '0, '0);
    offer(spq_pkg::OP_DEQ, '0, '0, '0);
    offer(spq_pkg::OP_DEQ, '0, '0, '0);
    offer(spq_pkg::OP_NONE, '0, '0, '0);
    settle();

    mix = MIX_EVEN;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 64 == 0) begin
        mix = mix_t'($urandom_range(0, 2));
        no_idle = ($urandom_range(0, 3) == 0);
      end
      case (mix)
        MIX_FILL:  enq_share = 70;
        MIX_DRAIN: enq_share = 25;
        default:   enq_share = 48;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < enq_share) op = spq_pkg::OP_ENQ;
      else if (roll >= 97) op = spq_pkg::OP_NONE;
      else op = ($urandom_range(0, 2) == 0) ? spq_pkg::OP_PEEK : spq_pkg::OP_DEQ;
      // A narrow priority range most of the time, so that ties are common.
      roll = $urandom_range(0, 9);
      if (roll < 6) prio = 16'($urandom_range(0, 7));
      else if (roll == 6) prio = 16'h0000;
      else if (roll == 7) prio = 16'hFFFF;
      else prio = 16'($urandom);
      offer(op, prio, 8'($urandom), {$urandom, $urandom});
      if (k == RANDOM_ITEMS / 2) settle();
    end

    no_idle = 1'b0;
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_datapath.sv
rtl/core/sorted_priority_queue_unit.sv
rtl/core/spq_checker.sv
tb/sorted_priority_queue_unit_test.sv
